>>> design/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  // default table size in frames
  localparam int FRAMES_DEF  = 1024;
  localparam int WORD_W      = 16;
  localparam int RANGE_W     = 11;
  localparam int FRAME_NUM_W = 10;

  // bit of the lowest frame in a word
  localparam logic [WORD_W-1:0] TOP_BIT = 16'h8000;

  // request codes
  localparam logic FUNC_TAKE = 1'b0;
  localparam logic FUNC_MARK = 1'b1;

  typedef enum logic [1:0] {
    FBA_IDLE,
    FBA_RUN,
    FBA_RESP
  } fba_state_e;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch request, restart word counter
    logic rd_en;   // read next bitmap word
    logic proc;    // evaluate the word read last cycle
  } fba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic issue_done;  // every word has been read
    logic proc_hit;    // take request found a free frame
    logic proc_last;   // last word is being evaluated
  } fba_sts_t;

endpackage

>>> design/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl
// Request sequencer: accepts a beat, walks the bitmap, presents the result.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fba_pkg::fba_sts_t sts_i,
  output fba_pkg::fba_cmd_t cmd_o
);

  fba_pkg::fba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fba_pkg::FBA_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fba_pkg::FBA_IDLE: begin
        if (in_valid_i) begin
          state_d = fba_pkg::FBA_RUN;
        end
      end
      fba_pkg::FBA_RUN: begin
        if (sts_i.proc_hit || sts_i.proc_last) begin
          state_d = fba_pkg::FBA_RESP;
        end
      end
      fba_pkg::FBA_RESP: begin
        if (out_ready_i) begin
          state_d = fba_pkg::FBA_IDLE;
        end
      end
      default: state_d = fba_pkg::FBA_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      fba_pkg::FBA_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      fba_pkg::FBA_RUN: begin
        cmd_o.rd_en = !sts_i.issue_done;
        cmd_o.proc  = 1'b1;
      end
      fba_pkg::FBA_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> design/fba_datapath.sv
// ----------------------------------------------------------------------------
// fba_datapath
// Bitmap store, word counter, leading-one search and range mask logic.
// ----------------------------------------------------------------------------
module fba_datapath #(
  parameter int FRAMES = fba_pkg::FRAMES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fba_pkg::fba_cmd_t               cmd_i,
  input  logic                            func_i,
  input  logic                            keep_others_i,
  input  logic [fba_pkg::RANGE_W-1:0]     range_start_i,
  input  logic [fba_pkg::RANGE_W-1:0]     range_end_i,
  output fba_pkg::fba_sts_t               sts_o,
  output logic [fba_pkg::FRAME_NUM_W-1:0] frame_number_o,
  output logic                            found_o
);

  localparam int WORDS = (FRAMES + fba_pkg::WORD_W - 1) / fba_pkg::WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNTW  = $clog2(WORDS + 1);
  localparam int FRW   = AW + 4;
  localparam int CMPW  = ((FRW > fba_pkg::RANGE_W) ? FRW : fba_pkg::RANGE_W) + 1;
  localparam int FNW   = (FRW > fba_pkg::FRAME_NUM_W) ? FRW : fba_pkg::FRAME_NUM_W;

  logic [fba_pkg::WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]           vld_q;

  logic                       op_q;
  logic                       keep_q;
  logic [fba_pkg::RANGE_W-1:0] first_q, stop_q;
  logic [CNTW-1:0]            cnt_q;
  logic                       pend_q;
  logic [AW-1:0]              pword_q;
  logic [fba_pkg::WORD_W-1:0] rd_data_q;
  logic                       rd_vld_q;
  logic [fba_pkg::FRAME_NUM_W-1:0] frame_q;
  logic                       found_q;

  logic [AW-1:0]              rd_addr;
  logic [fba_pkg::WORD_W-1:0] data_eff, range_mask, wr_data;
  logic [3:0]                 off;
  logic                       hit, we;
  logic [CMPW-1:0]            fr;
  logic [FNW-1:0]             fnum;

  assign rd_addr = cnt_q[AW-1:0];

  // request fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= fba_pkg::FUNC_TAKE;
    end else if (cmd_i.start) begin
      op_q <= func_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      keep_q  <= keep_others_i;
      first_q <= range_start_i;
      stop_q  <= range_end_i;
    end
  end

  // word counter and read stage flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.rd_en) begin
        cnt_q <= cnt_q + CNTW'(1);
      end
      pend_q <= cmd_i.rd_en;
    end
  end

  // bitmap read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
      pword_q   <= rd_addr;
    end
  end

  // never-written words read as zero
  assign data_eff = rd_vld_q ? rd_data_q : '0;

  // leading one = lowest frame of the word
  always_comb begin
    off = '0;
    for (int i = 0; i < fba_pkg::WORD_W; i++) begin
      if (data_eff[i]) begin
        off = 4'(fba_pkg::WORD_W - 1 - i);
      end
    end
  end

  // frames of this word inside [first, stop) and below FRAMES
  always_comb begin
    range_mask = '0;
    fr         = '0;
    for (int b = 0; b < fba_pkg::WORD_W; b++) begin
      fr = CMPW'({pword_q, 4'(b)});
      range_mask[fba_pkg::WORD_W-1-b] = (fr >= CMPW'(first_q)) && (fr < CMPW'(stop_q)) &&
                                        (fr < CMPW'(FRAMES));
    end
  end

  assign hit = pend_q && (op_q == fba_pkg::FUNC_TAKE) && (|data_eff);
  assign we  = cmd_i.proc && pend_q && ((op_q == fba_pkg::FUNC_MARK) || hit);

  always_comb begin
    if (op_q == fba_pkg::FUNC_MARK) begin
      wr_data = (keep_q ? data_eff : '0) | range_mask;
    end else begin
      wr_data = data_eff & ~(fba_pkg::TOP_BIT >> off);
    end
  end

  // bitmap write port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[pword_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[pword_q] <= 1'b1;
    end
  end

  // result
  assign fnum = FNW'({pword_q, off});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      frame_q <= '0;
    end else if (cmd_i.start) begin
      found_q <= 1'b0;
      frame_q <= '0;
    end else if (cmd_i.proc && hit) begin
      found_q <= 1'b1;
      frame_q <= fnum[fba_pkg::FRAME_NUM_W-1:0];
    end
  end

  assign sts_o.issue_done = (cnt_q == CNTW'(WORDS));
  assign sts_o.proc_hit   = cmd_i.proc && hit;
  assign sts_o.proc_last  = cmd_i.proc && pend_q && (pword_q == AW'(WORDS - 1));

  assign frame_number_o = frame_q;
  assign found_o        = found_q;

  // a hit always shows up as found in the next cycle
  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.proc_hit |=> found_q)
    else $error("take hit not reported");

  // mark requests never report a frame
  a_mark_nofound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == fba_pkg::FUNC_MARK) |-> !found_q)
    else $error("mark request reported a frame");

  // write-back and next read never hit the same word
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && cmd_i.rd_en) |-> (pword_q != rd_addr))
    else $error("read/write address clash");

endmodule

>>> design/frame_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_unit
// Free-frame bitmap allocator: take lowest free frame, or mark a range free and keep or clear the rest.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ---------------------------------
//  in       sink       in_valid_i/in_ready_o  func, keep_others, range_start,
//                                             range_end
//  out      source     out_valid_o/out_ready_i frame_number, found
//
//  One beat in gives one beat out. A request walks the bitmap one word per
//  cycle through the single read port of the bitmap RAM, which has a
//  registered output: a mark visits every word before result valid rises,
//  a take stops at the word holding the first free frame, or after the
//  last word if none is free.
//  Reset clears the per-word valid bits at once, so the table reads as all
//  frames in use with no clearing pass. in_ready_o is high only while idle;
//  a stalled result holds the unit until out_ready_i is taken.
//
module frame_bitmap_allocator_unit #(
  parameter int FRAMES = fba_pkg::FRAMES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic                            keep_others_i,
  input  logic [fba_pkg::RANGE_W-1:0]     range_start_i,
  input  logic [fba_pkg::RANGE_W-1:0]     range_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fba_pkg::FRAME_NUM_W-1:0] frame_number_o,
  output logic                            found_o
);

  fba_pkg::fba_cmd_t cmd;
  fba_pkg::fba_sts_t sts;

  // sequencing: idle -> walk words -> hold result
  fba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // bitmap RAM, search and mask logic, result registers
  fba_datapath #(
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .keep_others_i  (keep_others_i),
    .range_start_i  (range_start_i),
    .range_end_i    (range_end_i),
    .sts_o          (sts),
    .frame_number_o (frame_number_o),
    .found_o        (found_o)
  );

endmodule
